### hdl/assert_macros.svh
// Assertion macros used by the checker file of the key matrix block.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define KMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmd assertion failed");

// Next-cycle implication, switched off while reset is held.
`define KMD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmd assertion failed");

// Next-cycle implication that is also checked across reset.
`define KMD_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("kmd assertion failed");

`endif

### hdl/kmd_pkg.sv
// Types, constants and register codes of the key matrix debounce block.
// Depends on nothing; the other files of the block, apart from assert_macros.svh, use it.
package kmd_pkg;

  localparam int SCAN_W       = 40;
  localparam int IDX_W        = 6;
  localparam int LOCKOUT_BITS = 4;
  localparam int CFG_DW       = 64;
  localparam int CFG_AW       = 6;

  typedef logic [SCAN_W-1:0]       scan_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [LOCKOUT_BITS-1:0] lock_t;

  localparam int LOCK_MAX = (1 << LOCKOUT_BITS) - 1;

  // Event kinds as seen on the result channel.
  localparam logic [1:0] EV_NOTE_ON  = 2'd0;
  localparam logic [1:0] EV_NOTE_OFF = 2'd1;
  localparam logic [1:0] EV_CTRL     = 2'd2;

  localparam logic [6:0] VEL_PAD = 7'd127;
  localparam logic [6:0] VEL_KEY = 7'd100;
  localparam logic [6:0] VEL_CC  = 7'd127;
  localparam logic [6:0] VEL_OFF = 7'd0;

  // Bit map of one scan.
  localparam idx_t IDX_TOP   = idx_t'(SCAN_W - 1);
  localparam idx_t IDX_LAST  = idx_t'(0);
  localparam idx_t PAD_LAST  = idx_t'(7);
  localparam idx_t KEY_FIRST = idx_t'(8);
  localparam idx_t KEY_LAST  = idx_t'(32);
  localparam idx_t BTN_PLAY  = idx_t'(33);
  localparam idx_t BTN_MODE  = idx_t'(34);
  localparam idx_t BTN_POWER = idx_t'(35);

  typedef enum logic [2:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_PAD_NOTES  = 3'd1,
    REG_LOWEST_KEY = 3'd2,
    REG_PAD_CHAN   = 3'd3,
    REG_KEY_CHAN   = 3'd4,
    REG_PLAY_CC    = 3'd5,
    REG_MODE_CC    = 3'd6,
    REG_POWER_CC   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [3:0]  debounce;
    logic [55:0] pad_notes;
    logic [6:0]  lowest_key;
    logic [3:0]  pad_chan;
    logic [3:0]  key_chan;
    logic [6:0]  play_cc;
    logic [6:0]  mode_cc;
    logic [6:0]  power_cc;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    debounce:   4'd10,
    pad_notes:  56'd0,
    lowest_key: 7'd48,
    pad_chan:   4'd9,
    key_chan:   4'd0,
    play_cc:    7'd0,
    mode_cc:    7'd0,
    power_cc:   7'd0
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] chan;
    logic [6:0] num;
    logic [6:0] val;
  } evt_t;

  // Walker to event queue: one event and the end-of-scan marker.
  typedef struct packed {
    logic push;
    logic scan_end;
    evt_t evt;
  } walk_ctl_t;

endpackage

### hdl/kmd_if.sv
// Valid/ready channel interfaces for scans in and events out.
// Depends on kmd_pkg for the payload types.
interface kmd_scan_if;
  logic               valid;
  logic               ready;
  kmd_pkg::scan_t     scan_bits;

  modport source (output valid, output scan_bits, input ready);
  modport sink   (input valid, input scan_bits, output ready);
endinterface

interface kmd_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [3:0] midi_channel;
  logic [6:0] note_or_controller;
  logic [6:0] event_value;
  logic       last_of_scan;

  modport source (output valid, output event_kind, output midi_channel,
                  output note_or_controller, output event_value,
                  output last_of_scan, input ready);
  modport sink   (input valid, input event_kind, input midi_channel,
                  input note_or_controller, input event_value,
                  input last_of_scan, output ready);
endinterface

### hdl/kmd_cfg_regs.sv
// APB-style register file holding the eight configuration registers.
// Depends on kmd_pkg for the register codes and the cfg_t layout.
module kmd_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kmd_pkg::CFG_AW-1:0]   paddr,
  input  logic [kmd_pkg::CFG_DW-1:0]   pwdata,
  output logic [kmd_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready,
  output kmd_pkg::cfg_t                cfg
);
  import kmd_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_idx_t'(paddr[CFG_AW-1:3]);
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_DEBOUNCE:   cfg_nxt.debounce   = pwdata[3:0];
        REG_PAD_NOTES:  cfg_nxt.pad_notes  = pwdata[55:0];
        REG_LOWEST_KEY: cfg_nxt.lowest_key = pwdata[6:0];
        REG_PAD_CHAN:   cfg_nxt.pad_chan   = pwdata[3:0];
        REG_KEY_CHAN:   cfg_nxt.key_chan   = pwdata[3:0];
        REG_PLAY_CC:    cfg_nxt.play_cc    = pwdata[6:0];
        REG_MODE_CC:    cfg_nxt.mode_cc    = pwdata[6:0];
        REG_POWER_CC:   cfg_nxt.power_cc   = pwdata[6:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEBOUNCE:   prdata = CFG_DW'(cfg_r.debounce);
      REG_PAD_NOTES:  prdata = CFG_DW'(cfg_r.pad_notes);
      REG_LOWEST_KEY: prdata = CFG_DW'(cfg_r.lowest_key);
      REG_PAD_CHAN:   prdata = CFG_DW'(cfg_r.pad_chan);
      REG_KEY_CHAN:   prdata = CFG_DW'(cfg_r.key_chan);
      REG_PLAY_CC:    prdata = CFG_DW'(cfg_r.play_cc);
      REG_MODE_CC:    prdata = CFG_DW'(cfg_r.mode_cc);
      REG_POWER_CC:   prdata = CFG_DW'(cfg_r.power_cc);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### hdl/kmd_scan_walker.sv
// Bit-serial scan walker: rotating shift chains for the accepted state and
// the lockout counters, one scan bit per cycle while q_ready is high. Depends on kmd_pkg and kmd_if.
module kmd_scan_walker (
  input  logic                  clk,
  input  logic                  rst_n,
  kmd_scan_if.sink              in_if,
  input  kmd_pkg::cfg_t         cfg,
  input  logic                  q_ready,
  output kmd_pkg::walk_ctl_t    ctl
);
  import kmd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  scan_t  scan_sr_r, scan_sr_nxt;
  scan_t  acc_sr_r, acc_sr_nxt;
  lock_t  lock_sr_r [SCAN_W];
  lock_t  lock_sr_nxt [SCAN_W];
  idx_t   idx_r, idx_nxt;

  logic   accept;
  logic   adv;
  logic   head_scan;
  logic   head_acc;
  lock_t  head_lock;
  logic   take;
  logic   new_acc;
  lock_t  lock_load;
  lock_t  lock_ld;
  lock_t  new_lock;
  logic   pressed;
  logic   emit;
  evt_t   evt;

  assign in_if.ready = (state_r == ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign adv         = (state_r == ST_WALK) && q_ready;

  // Counter load saturates at what the counter can hold.
  assign lock_load = (9'(cfg.debounce) > 9'(LOCK_MAX)) ? lock_t'(LOCK_MAX)
                                                       : lock_t'(cfg.debounce);

  assign head_scan = scan_sr_r[SCAN_W-1];
  assign head_acc  = acc_sr_r[SCAN_W-1];
  assign head_lock = lock_sr_r[SCAN_W-1];
  assign take      = (head_scan ^ head_acc) && (head_lock == '0);
  assign new_acc   = take ? head_scan : head_acc;
  assign lock_ld   = take ? lock_load : head_lock;
  assign new_lock  = (lock_ld != '0) ? lock_ld - lock_t'(1) : lock_ld;
  assign pressed   = !head_scan;

  always_comb begin
    emit     = take;
    evt.kind = pressed ? EV_NOTE_ON : EV_NOTE_OFF;
    evt.chan = cfg.key_chan;
    evt.num  = cfg.lowest_key;
    evt.val  = pressed ? VEL_CC : VEL_OFF;
    priority if (idx_r <= PAD_LAST) begin
      evt.chan = cfg.pad_chan;
      evt.num  = cfg.pad_notes[7*idx_r[2:0] +: 7];
      evt.val  = pressed ? VEL_PAD : VEL_OFF;
    end else if (idx_r <= KEY_LAST) begin
      evt.num  = cfg.lowest_key + 7'(idx_r - KEY_FIRST);
      evt.val  = pressed ? VEL_KEY : VEL_OFF;
    end else if (idx_r == BTN_PLAY) begin
      evt.kind = EV_CTRL;
      evt.num  = cfg.play_cc;
    end else if (idx_r == BTN_MODE) begin
      evt.kind = EV_CTRL;
      evt.num  = cfg.mode_cc;
    end else if (idx_r == BTN_POWER) begin
      evt.kind = EV_CTRL;
      evt.num  = cfg.power_cc;
    end else begin
      emit = 1'b0;
    end
  end

  assign ctl.push     = adv && emit;
  assign ctl.scan_end = adv && (idx_r == IDX_LAST);
  assign ctl.evt      = evt;

  always_comb begin
    state_nxt   = state_r;
    scan_sr_nxt = scan_sr_r;
    acc_sr_nxt  = acc_sr_r;
    lock_sr_nxt = lock_sr_r;
    idx_nxt     = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          scan_sr_nxt = in_if.scan_bits;
          idx_nxt     = IDX_TOP;
          state_nxt   = ST_WALK;
        end
      end
      ST_WALK: begin
        if (adv) begin
          scan_sr_nxt = {scan_sr_r[SCAN_W-2:0], 1'b0};
          acc_sr_nxt  = {acc_sr_r[SCAN_W-2:0], new_acc};
          for (int k = SCAN_W - 1; k > 0; k--) begin
            lock_sr_nxt[k] = lock_sr_r[k-1];
          end
          lock_sr_nxt[0] = new_lock;
          idx_nxt        = idx_r - idx_t'(1);
          if (idx_r == IDX_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      acc_sr_r  <= '1;
      lock_sr_r <= '{default: '0};
      idx_r     <= IDX_TOP;
    end else begin
      state_r   <= state_nxt;
      acc_sr_r  <= acc_sr_nxt;
      lock_sr_r <= lock_sr_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_sr_r <= scan_sr_nxt;
  end

endmodule

### hdl/kmd_event_queue.sv
// Holding stage and output register for events; an event is held back one
// step so the final event of a scan can be flagged. Depends on kmd_pkg, kmd_if.
module kmd_event_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kmd_pkg::walk_ctl_t   ctl,
  output logic                 q_ready,
  kmd_event_if.source          out_if
);
  import kmd_pkg::*;

  evt_t hold_r, hold_nxt;
  logic hold_vld_r, hold_vld_nxt;
  logic hold_fin_r, hold_fin_nxt;
  evt_t out_r, out_nxt;
  logic out_last_r, out_last_nxt;
  logic out_vld_r, out_vld_nxt;
  logic out_free;

  assign out_free = !out_vld_r || out_if.ready;
  assign q_ready  = out_free && !hold_fin_r;

  always_comb begin
    hold_nxt     = hold_r;
    hold_vld_nxt = hold_vld_r;
    hold_fin_nxt = hold_fin_r;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    out_vld_nxt  = out_vld_r && !out_if.ready;
    priority if (hold_fin_r) begin
      // The held event closes its scan; send it once the output is free.
      if (out_free) begin
        out_nxt      = hold_r;
        out_last_nxt = 1'b1;
        out_vld_nxt  = 1'b1;
        hold_vld_nxt = 1'b0;
        hold_fin_nxt = 1'b0;
      end
    end else if (ctl.push) begin
      if (hold_vld_r) begin
        out_nxt      = hold_r;
        out_last_nxt = 1'b0;
        out_vld_nxt  = 1'b1;
      end
      hold_nxt     = ctl.evt;
      hold_vld_nxt = 1'b1;
      hold_fin_nxt = ctl.scan_end;
    end else if (ctl.scan_end && hold_vld_r) begin
      out_nxt      = hold_r;
      out_last_nxt = 1'b1;
      out_vld_nxt  = 1'b1;
      hold_vld_nxt = 1'b0;
    end else begin
      // Nothing moves into the holding stage on this cycle.
      hold_nxt = hold_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      hold_fin_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      hold_fin_r <= hold_fin_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_if.valid              = out_vld_r;
  assign out_if.event_kind         = out_r.kind;
  assign out_if.midi_channel       = out_r.chan;
  assign out_if.note_or_controller = out_r.num;
  assign out_if.event_value        = out_r.val;
  assign out_if.last_of_scan       = out_last_r;

endmodule

### hdl/key_matrix_debounce_event_mapper.sv
// Channel     Direction  Handshake              Payload
// in_if       sink       valid/ready            scan_bits (40 bits, 0 = pressed)
// out_if      source     valid/ready            kind, channel, note/cc, value, last
// cfg_*       APB slave  psel/penable/pready    eight registers, 64-bit data, 8-byte step
//
// A scan is taken while the block is idle and then walked bit by bit, bit 39
// first, through the 40-entry shift chains. A stalled result output freezes
// the walk until the output register frees up. in_if.ready is high only
// while no walk is running. Reset is synchronous and active low: all
// buttons released, every lockout counter cleared, registers at defaults.
//
// Top level of the key matrix scanner with per-button debounce lockout and
// event mapping. Depends on kmd_pkg, kmd_if, kmd_cfg_regs, kmd_scan_walker
// and kmd_event_queue.
module key_matrix_debounce_event_mapper (
  input  logic                        clk,
  input  logic                        rst_n,
  kmd_scan_if.sink                    in_if,
  kmd_event_if.source                 out_if,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [kmd_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [kmd_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [kmd_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import kmd_pkg::*;

  cfg_t      cfg;
  walk_ctl_t walk_ctl;
  logic      q_ready;

  // Configuration registers. Writes must arrive only while no scan is in
  // flight; the block does not enforce this, and the walker reads them directly.
  kmd_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // The walker rotates the accepted-state and lockout chains by one position
  // per cycle while q_ready is high. The chain head is compared with the head
  // of the scan register; a change on an unlocked bit flips the accepted bit,
  // reloads its counter and may produce an event. The counter is decremented
  // on its way back into the tail, which is the same as the end-of-scan
  // decrement since each counter passes the head exactly once per scan.
  kmd_scan_walker u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .cfg     (cfg),
    .q_ready (q_ready),
    .ctl     (walk_ctl)
  );

  // Events are held back by one so that the final one of a scan can carry
  // the last-of-scan flag; the output register holds the result for the
  // downstream ready, which also reaches the walker through q_ready.
  kmd_event_queue u_event_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (walk_ctl),
    .q_ready (q_ready),
    .out_if  (out_if)
  );

endmodule

### hdl/kmd_checker.sv
// Port-level checker for the key matrix block, attached by bind.
// Depends on kmd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kmd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [3:0] out_chan,
  input logic [6:0] out_num,
  input logic [6:0] out_val,
  input logic       out_last
);
  import kmd_pkg::*;

  // Once a scan is taken, in_if.ready is low; this checks the start of the walk.
  `KMD_ASSERT_NXT(a_busy_after_scan, clk, rst_n, in_valid && in_ready, !in_ready)

  // A result that is not taken stays put.
  `KMD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({out_kind, out_chan, out_num, out_val, out_last}))

  // Note on always carries a velocity, note off never does.
  `KMD_ASSERT_IMP(a_note_velocity, clk, rst_n, out_valid && (out_kind == EV_NOTE_ON || out_kind == EV_NOTE_OFF), (out_kind == EV_NOTE_ON) == (out_val != VEL_OFF))

  // Nothing is offered in the cycle after reset.
  `KMD_ASSERT_NXT_ALL(a_reset_quiet, clk, !rst_n, !out_valid)

endmodule

bind key_matrix_debounce_event_mapper kmd_checker u_kmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_kind  (out_if.event_kind),
  .out_chan  (out_if.midi_channel),
  .out_num   (out_if.note_or_controller),
  .out_val   (out_if.event_value),
  .out_last  (out_if.last_of_scan)
);
